// ===== hdl/csv_field_tokenizer_defines.svh =====
// Assertion macros used by the tokenizer back end.
// Both expect signals named clk and arst_n in the module that uses them.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cft_pkg.sv =====
package cft_pkg;

	localparam int MAX_NEEDLE  = 4;
	localparam int COUNT_BITS  = 16;
	localparam int LINE_BITS   = 32;
	localparam int FILL_BITS   = $clog2(MAX_NEEDLE + 1);
	localparam int QDEPTH      = 4;
	localparam int QPTR_BITS   = $clog2(QDEPTH);
	localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

	localparam logic [7:0] BOM_B0 = 8'hEF;
	localparam logic [7:0] BOM_B1 = 8'hBB;
	localparam logic [7:0] BOM_B2 = 8'hBF;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [2:0] PH_REC   = 3'd0;
	localparam logic [2:0] PH_FIELD = 3'd1;
	localparam logic [2:0] PH_UNQ   = 3'd2;
	localparam logic [2:0] PH_QUO   = 3'd3;
	localparam logic [2:0] PH_AFTER = 3'd4;

	localparam logic [1:0] KIND_CONTENT   = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_ERROR     = 2'd2;

	localparam logic [1:0] TERM_SEP = 2'd0;
	localparam logic [1:0] TERM_EOL = 2'd1;
	localparam logic [1:0] TERM_EOT = 2'd2;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
	localparam logic [2:0] ERR_AFTER_QUOTE  = 3'd2;
	localparam logic [2:0] ERR_STRAY_QUOTE  = 3'd3;
	localparam logic [2:0] ERR_COUNT        = 3'd4;
	localparam logic [2:0] ERR_OVER_HEADER  = 3'd5;

	localparam logic [1:0] T_NO   = 2'd0;
	localparam logic [1:0] T_YES  = 2'd1;
	localparam logic [1:0] T_WAIT = 2'd2;

	localparam logic [1:0] BOM_START = 2'd0;
	localparam logic [1:0] BOM_ONE   = 2'd1;
	localparam logic [1:0] BOM_TWO   = 2'd2;
	localparam logic [1:0] BOM_DONE  = 2'd3;

	localparam logic [1:0] HM_FIRST    = 2'd1;
	localparam logic [1:0] HM_SUPPLIED = 2'd2;

	localparam logic [2:0] REG_SEP_BYTES    = 3'd0;
	localparam logic [2:0] REG_SEP_LEN      = 3'd1;
	localparam logic [2:0] REG_QUOTE_BYTES  = 3'd2;
	localparam logic [2:0] REG_QUOTE_LEN    = 3'd3;
	localparam logic [2:0] REG_STRICT_MODE  = 3'd4;
	localparam logic [2:0] REG_HEADER_MODE  = 3'd5;
	localparam logic [2:0] REG_HEADER_COUNT = 3'd6;

	typedef logic [MAX_NEEDLE-1:0][7:0] la_t;

	typedef struct packed {
		logic       is_fin;
		logic [7:0] data;
		logic       item_end;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [7:0]            byte_val;
		logic [1:0]            term;
		logic [COUNT_BITS-1:0] idx;
		logic                  hdr;
		logic [LINE_BITS-1:0]  line;
		logic [2:0]            err;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [31:0] sep_bytes;
		logic [2:0]  sep_len;
		logic [31:0] quote_bytes;
		logic [2:0]  quote_len;
		logic        strict_mode;
		logic [1:0]  header_mode;
		logic [15:0] header_count;
	} cfg_t;

	function automatic logic [FILL_BITS-1:0] nlen(input logic [2:0] l);
		if (l == 3'd0)
			return FILL_BITS'(1);
		if (int'(l) > MAX_NEEDLE)
			return FILL_BITS'(MAX_NEEDLE);
		return FILL_BITS'(l);
	endfunction

	function automatic logic [7:0] nbyte(input logic [31:0] pat, input int i);
		return 8'(pat >> (8 * i));
	endfunction

	// Compare the head of the lookahead with a needle; T_WAIT when the bytes held
	// so far agree but do not yet reach the needle's length (T_NO instead at end of text).
	function automatic logic [1:0] needle_test(input la_t la, input logic [FILL_BITS-1:0] fill,
			input logic [31:0] pat, input logic [2:0] len, input logic eof);
		logic [FILL_BITS-1:0] n;
		logic [1:0]           r;
		logic                 done;
		n = nlen(len);
		r = T_YES;
		done = 1'b0;
		for (int i = 0; i < MAX_NEEDLE; i++) begin
			if (!done && i < int'(n)) begin
				if (i >= int'(fill)) begin
					r = eof ? T_NO : T_WAIT;
					done = 1'b1;
				end else if (la[i] != nbyte(pat, i)) begin
					r = T_NO;
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
			input logic [1:0] term, input logic [COUNT_BITS-1:0] idx, input logic hdr,
			input logic [LINE_BITS-1:0] line, input logic [2:0] err);
		res_t r;
		r.kind = kind;
		r.byte_val = b;
		r.term = term;
		r.idx = idx;
		r.hdr = hdr;
		r.line = line;
		r.err = err;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(input logic is_fin, input logic [7:0] b);
		cmd_t c;
		c.is_fin = is_fin;
		c.data = b;
		c.item_end = 1'b0;
		return c;
	endfunction

endpackage

// ===== hdl/cft_front.sv =====
module cft_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [7:0]        data,
	output logic              push_valid,
	input  logic              push_ready,
	output cft_pkg::cmd_t     push_cmd
);
	import cft_pkg::*;

	cmd_t       pend_q [3];
	logic [1:0] pend_cnt_q;
	logic [1:0] bom_q;

	cmd_t       list [3];
	logic [1:0] list_cnt;
	logic [1:0] bom_n;
	logic       accept;
	logic       pushed;

	assign push_valid = (pend_cnt_q != 2'd0);
	assign push_cmd   = pend_q[0];
	assign pushed     = push_valid && push_ready;
	assign in_ready   = (pend_cnt_q == 2'd0) || (pend_cnt_q == 2'd1 && push_ready);
	assign accept     = in_valid && in_ready;

	// A held byte-order-mark prefix is replayed as text when the mark turns out false.
	always_comb begin
		list[0] = mk_cmd(1'b0, data);
		list[1] = mk_cmd(1'b0, data);
		list[2] = mk_cmd(1'b0, data);
		list_cnt = 2'd0;
		bom_n = bom_q;
		if (!op) begin
			case (bom_q)
				BOM_START: begin
					if (data == BOM_B0) begin
						bom_n = BOM_ONE;
					end else begin
						bom_n = BOM_DONE;
						list_cnt = 2'd1;
					end
				end
				BOM_ONE: begin
					if (data == BOM_B1) begin
						bom_n = BOM_TWO;
					end else begin
						bom_n = BOM_DONE;
						list[0] = mk_cmd(1'b0, BOM_B0);
						list_cnt = 2'd2;
					end
				end
				BOM_TWO: begin
					bom_n = BOM_DONE;
					if (data != BOM_B2) begin
						list[0] = mk_cmd(1'b0, BOM_B0);
						list[1] = mk_cmd(1'b0, BOM_B1);
						list_cnt = 2'd3;
					end
				end
				default: begin
					list_cnt = 2'd1;
				end
			endcase
		end else begin
			bom_n = BOM_START;
			case (bom_q)
				BOM_ONE: begin
					list[0] = mk_cmd(1'b0, BOM_B0);
					list[1] = mk_cmd(1'b1, data);
					list_cnt = 2'd2;
				end
				BOM_TWO: begin
					list[0] = mk_cmd(1'b0, BOM_B0);
					list[1] = mk_cmd(1'b0, BOM_B1);
					list[2] = mk_cmd(1'b1, data);
					list_cnt = 2'd3;
				end
				default: begin
					list[0] = mk_cmd(1'b1, data);
					list_cnt = 2'd1;
				end
			endcase
		end
		case (list_cnt)
			2'd1: list[0].item_end = 1'b1;
			2'd2: list[1].item_end = 1'b1;
			2'd3: list[2].item_end = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
			bom_q <= BOM_START;
		end else if (accept) begin
			pend_cnt_q <= list_cnt;
			bom_q <= bom_n;
		end else if (pushed) begin
			pend_cnt_q <= pend_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q[0] <= list[0];
			pend_q[1] <= list[1];
			pend_q[2] <= list[2];
		end else if (pushed) begin
			pend_q[0] <= pend_q[1];
			pend_q[1] <= pend_q[2];
		end
	end

endmodule

// ===== hdl/cft_queue.sv =====
module cft_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cft_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output cft_pkg::cmd_t pop_cmd
);
	import cft_pkg::*;

	cmd_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (cnt_q != QCNT_BITS'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_cmd;
	end

endmodule

// ===== hdl/cft_back.sv =====
`include "csv_field_tokenizer_defines.svh"

module cft_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cft_pkg::cfg_t cfg,
	input  logic          q_valid,
	input  cft_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output cft_pkg::res_t res
);
	import cft_pkg::*;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_QEMIT = 2'd1;
	localparam logic [1:0] ST_REC   = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]            st_q, st_n;
	logic [2:0]            phase_q, phase_n;
	la_t                   la_q, la_n;
	logic [FILL_BITS-1:0]  fill_q, fill_n;
	logic                  pcr_q, pcr_n;
	logic [LINE_BITS-1:0]  line_q, line_n;
	logic [LINE_BITS-1:0]  fsl_q, fsl_n;
	logic [LINE_BITS-1:0]  rsl_q, rsl_n;
	logic [COUNT_BITS-1:0] fc_q, fc_n;
	logic [COUNT_BITS-1:0] exp_q, exp_n;
	logic                  have_q, have_n;
	logic                  hs_q, hs_n;
	logic                  failed_q, failed_n;
	logic                  cur_end_q, cur_end_n;
	logic                  cur_eof_q, cur_eof_n;
	logic                  rec_fin_q, rec_fin_n;
	logic [FILL_BITS-2:0]  qi_q, qi_n;
	res_t                  hold_q;
	logic                  hold_v_q;
	res_t                  out_q;
	logic                  out_v_q;

	logic                  emit_req;
	res_t                  res_new;
	logic                  flush;
	logic                  pop_want;
	logic                  stall;
	logic                  emit_ok;
	logic                  stuck;
	logic                  do_init;
	logic [1:0]            tq;
	logic [1:0]            ts;
	logic [7:0]            b;
	logic [FILL_BITS-1:0]  nq;
	logic [FILL_BITS-1:0]  ns;
	logic                  in_hdr;
	logic [COUNT_BITS-1:0] fc_inc;
	logic [LINE_BITS-1:0]  line_inc;
	logic [COUNT_BITS-1:0] rexp;
	logic                  rhave;
	logic                  keys;
	logic                  err4;
	logic                  err5;

	assign emit_ok   = !hold_v_q || !out_v_q || out_ready;
	assign stall     = (emit_req || flush) && !emit_ok;
	assign q_pop     = pop_want && !stall;
	assign out_valid = out_v_q;
	assign res       = out_q;

	assign tq       = needle_test(la_q, fill_q, cfg.quote_bytes, cfg.quote_len, cur_eof_q);
	assign ts       = needle_test(la_q, fill_q, cfg.sep_bytes, cfg.sep_len, cur_eof_q);
	assign b        = la_q[0];
	assign nq       = nlen(cfg.quote_len);
	assign ns       = nlen(cfg.sep_len);
	assign in_hdr   = (cfg.header_mode == HM_FIRST) && !hs_q;
	assign fc_inc   = (fc_q != '1) ? fc_q + 1'b1 : fc_q;
	assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;

	// Record checks once the last field of a record has ended.
	always_comb begin
		rexp = exp_q;
		rhave = have_q;
		if (cfg.header_mode == HM_SUPPLIED) begin
			rexp = COUNT_BITS'(cfg.header_count);
			rhave = 1'b1;
		end
		keys = (cfg.header_mode == HM_SUPPLIED) || (cfg.header_mode == HM_FIRST && hs_q);
		err4 = cfg.strict_mode && rhave && (fc_q != rexp);
		err5 = !err4 && keys && (fc_q > rexp);
	end

	always_comb begin
		st_n = st_q;
		phase_n = phase_q;
		la_n = la_q;
		fill_n = fill_q;
		pcr_n = pcr_q;
		line_n = line_q;
		fsl_n = fsl_q;
		rsl_n = rsl_q;
		fc_n = fc_q;
		exp_n = exp_q;
		have_n = have_q;
		hs_n = hs_q;
		failed_n = failed_q;
		cur_end_n = cur_end_q;
		cur_eof_n = cur_eof_q;
		rec_fin_n = rec_fin_q;
		qi_n = qi_q;
		emit_req = 1'b0;
		res_new = mk_res(KIND_CONTENT, 8'h00, TERM_SEP, fc_q, in_hdr, fsl_q, ERR_NONE);
		flush = 1'b0;
		pop_want = 1'b0;
		stuck = 1'b0;
		do_init = 1'b0;

		case (st_q)
			ST_RUN: begin
				if (failed_q || fill_q == '0) begin
					stuck = 1'b1;
				end else begin
					pcr_n = 1'b0;
					if (pcr_q && b == CH_LF) begin
						// LF completing a CRLF pair.
						if (phase_q == PH_QUO) begin
							emit_req = 1'b1;
							res_new = mk_res(KIND_CONTENT, b, TERM_SEP, fc_q, in_hdr,
								fsl_q, ERR_NONE);
						end
						la_n = la_t'(la_q >> 8);
						fill_n = fill_q - 1'b1;
					end else begin
						case (phase_q)
							PH_REC: begin
								rsl_n = line_q;
								fc_n = '0;
								phase_n = PH_FIELD;
							end
							PH_FIELD: begin
								fsl_n = line_q;
								if (tq == T_WAIT) begin
									stuck = 1'b1;
								end else if (tq == T_YES) begin
									la_n = la_t'(la_q >> {nq, 3'b000});
									fill_n = fill_q - nq;
									phase_n = PH_QUO;
								end else begin
									phase_n = PH_UNQ;
								end
							end
							PH_UNQ: begin
								if (ts == T_WAIT) begin
									stuck = 1'b1;
								end else if (ts == T_YES) begin
									la_n = la_t'(la_q >> {ns, 3'b000});
									fill_n = fill_q - ns;
									emit_req = 1'b1;
									res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_SEP, fc_q,
										in_hdr, fsl_q, ERR_NONE);
									fc_n = fc_inc;
									phase_n = PH_FIELD;
								end else if (b == CH_LF || b == CH_CR) begin
									la_n = la_t'(la_q >> 8);
									fill_n = fill_q - 1'b1;
									line_n = line_inc;
									pcr_n = (b == CH_CR);
									emit_req = 1'b1;
									res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_EOL, fc_q,
										in_hdr, fsl_q, ERR_NONE);
									fc_n = fc_inc;
									phase_n = PH_REC;
									rec_fin_n = 1'b0;
									st_n = ST_REC;
								end else if (tq == T_WAIT) begin
									stuck = 1'b1;
								end else if (tq == T_YES) begin
									emit_req = 1'b1;
									res_new = mk_res(KIND_ERROR, 8'h00, TERM_SEP, '0, 1'b0,
										fsl_q, ERR_STRAY_QUOTE);
									failed_n = 1'b1;
								end else begin
									emit_req = 1'b1;
									res_new = mk_res(KIND_CONTENT, b, TERM_SEP, fc_q, in_hdr,
										fsl_q, ERR_NONE);
									la_n = la_t'(la_q >> 8);
									fill_n = fill_q - 1'b1;
								end
							end
							PH_QUO: begin
								if (tq == T_WAIT) begin
									stuck = 1'b1;
								end else if (tq == T_YES) begin
									la_n = la_t'(la_q >> {nq, 3'b000});
									fill_n = fill_q - nq;
									phase_n = PH_AFTER;
								end else begin
									emit_req = 1'b1;
									res_new = mk_res(KIND_CONTENT, b, TERM_SEP, fc_q, in_hdr,
										fsl_q, ERR_NONE);
									if (b == CH_LF || b == CH_CR) begin
										line_n = line_inc;
										pcr_n = (b == CH_CR);
									end
									la_n = la_t'(la_q >> 8);
									fill_n = fill_q - 1'b1;
								end
							end
							default: begin
								if (tq == T_WAIT) begin
									stuck = 1'b1;
								end else if (tq == T_YES) begin
									// Doubled quote: the quote bytes go out one per cycle while the output does not stall.
									qi_n = '0;
									st_n = ST_QEMIT;
								end else if (ts == T_WAIT) begin
									stuck = 1'b1;
								end else if (ts == T_YES) begin
									la_n = la_t'(la_q >> {ns, 3'b000});
									fill_n = fill_q - ns;
									emit_req = 1'b1;
									res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_SEP, fc_q,
										in_hdr, fsl_q, ERR_NONE);
									fc_n = fc_inc;
									phase_n = PH_FIELD;
								end else if (b == CH_LF || b == CH_CR) begin
									la_n = la_t'(la_q >> 8);
									fill_n = fill_q - 1'b1;
									line_n = line_inc;
									pcr_n = (b == CH_CR);
									emit_req = 1'b1;
									res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_EOL, fc_q,
										in_hdr, fsl_q, ERR_NONE);
									fc_n = fc_inc;
									phase_n = PH_REC;
									rec_fin_n = 1'b0;
									st_n = ST_REC;
								end else begin
									emit_req = 1'b1;
									res_new = mk_res(KIND_ERROR, 8'h00, TERM_SEP, '0, 1'b0,
										fsl_q, ERR_AFTER_QUOTE);
									failed_n = 1'b1;
								end
							end
						endcase
					end
				end

				// No further decision is possible: close the word and take the next one, or finish after the end mark.
				if (stuck) begin
					if (cur_eof_q) begin
						st_n = ST_FIN;
					end else begin
						if (cur_end_q) begin
							flush = hold_v_q;
							cur_end_n = 1'b0;
						end
						if (q_valid) begin
							pop_want = 1'b1;
							cur_end_n = q_cmd.item_end;
							if (q_cmd.is_fin) begin
								cur_eof_n = 1'b1;
							end else if (!failed_q && int'(fill_q) < MAX_NEEDLE) begin
								la_n[fill_q[FILL_BITS-2:0]] = q_cmd.data;
								fill_n = fill_q + 1'b1;
							end
						end
					end
				end
			end

			ST_QEMIT: begin
				emit_req = 1'b1;
				res_new = mk_res(KIND_CONTENT, nbyte(cfg.quote_bytes, int'(qi_q)), TERM_SEP,
					fc_q, in_hdr, fsl_q, ERR_NONE);
				if (FILL_BITS'(qi_q) + 1'b1 == nq) begin
					la_n = la_t'(la_q >> {nq, 3'b000});
					fill_n = fill_q - nq;
					phase_n = PH_QUO;
					st_n = ST_RUN;
				end else begin
					qi_n = qi_q + 1'b1;
				end
			end

			ST_REC: begin
				st_n = ST_RUN;
				if (cfg.header_mode == HM_FIRST && !hs_q) begin
					hs_n = 1'b1;
					exp_n = fc_q;
					have_n = 1'b1;
				end else begin
					if (cfg.strict_mode && !rhave) begin
						exp_n = fc_q;
						have_n = 1'b1;
					end
					if (err4 || err5) begin
						emit_req = 1'b1;
						res_new = mk_res(KIND_ERROR, 8'h00, TERM_SEP, '0, 1'b0, rsl_q,
							err4 ? ERR_COUNT : ERR_OVER_HEADER);
						failed_n = 1'b1;
					end
				end
				if (rec_fin_q) begin
					do_init = 1'b1;
					cur_eof_n = 1'b0;
				end
			end

			default: begin
				// End of text.
				st_n = ST_RUN;
				if (failed_q) begin
					do_init = 1'b1;
					cur_eof_n = 1'b0;
				end else begin
					case (phase_q)
						PH_FIELD: begin
							fsl_n = line_q;
							emit_req = 1'b1;
							res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_EOT, fc_q, in_hdr,
								line_q, ERR_NONE);
							fc_n = fc_inc;
							rec_fin_n = 1'b1;
							st_n = ST_REC;
						end
						PH_UNQ, PH_AFTER: begin
							emit_req = 1'b1;
							res_new = mk_res(KIND_FIELD_END, 8'h00, TERM_EOT, fc_q, in_hdr,
								fsl_q, ERR_NONE);
							fc_n = fc_inc;
							rec_fin_n = 1'b1;
							st_n = ST_REC;
						end
						PH_QUO: begin
							emit_req = 1'b1;
							res_new = mk_res(KIND_ERROR, 8'h00, TERM_SEP, '0, 1'b0, fsl_q,
								ERR_UNTERMINATED);
							failed_n = 1'b1;
							do_init = 1'b1;
							cur_eof_n = 1'b0;
						end
						default: begin
							do_init = 1'b1;
							cur_eof_n = 1'b0;
						end
					endcase
				end
			end
		endcase

		if (do_init) begin
			phase_n = PH_REC;
			fill_n = '0;
			pcr_n = 1'b0;
			line_n = LINE_BITS'(1);
			fsl_n = LINE_BITS'(1);
			rsl_n = LINE_BITS'(1);
			fc_n = '0;
			exp_n = '0;
			have_n = 1'b0;
			hs_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			phase_q <= PH_REC;
			fill_q <= '0;
			pcr_q <= 1'b0;
			line_q <= LINE_BITS'(1);
			fsl_q <= LINE_BITS'(1);
			rsl_q <= LINE_BITS'(1);
			fc_q <= '0;
			exp_q <= '0;
			have_q <= 1'b0;
			hs_q <= 1'b0;
			failed_q <= 1'b0;
			cur_end_q <= 1'b0;
			cur_eof_q <= 1'b0;
			rec_fin_q <= 1'b0;
			qi_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (!stall) begin
				st_q <= st_n;
				phase_q <= phase_n;
				fill_q <= fill_n;
				pcr_q <= pcr_n;
				line_q <= line_n;
				fsl_q <= fsl_n;
				rsl_q <= rsl_n;
				fc_q <= fc_n;
				exp_q <= exp_n;
				have_q <= have_n;
				hs_q <= hs_n;
				failed_q <= failed_n;
				cur_end_q <= cur_end_n;
				cur_eof_q <= cur_eof_n;
				rec_fin_q <= rec_fin_n;
				qi_q <= qi_n;
			end
			// The newest word waits in the hold register until it is known whether
			// it is the last one of its input.
			if (!stall && emit_req) begin
				hold_v_q <= 1'b1;
				if (hold_v_q)
					out_v_q <= 1'b1;
				else if (out_ready)
					out_v_q <= 1'b0;
			end else if (!stall && flush) begin
				hold_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall)
			la_q <= la_n;
		if (!stall && emit_req) begin
			hold_q <= res_new;
			if (hold_v_q)
				out_q <= hold_q;
		end else if (!stall && flush) begin
			out_q <= hold_q;
			out_q.last <= 1'b1;
		end
	end

	`CFT_ASSERT_NXT(a_failed_sticky, failed_q, failed_q, "error state was left without reset")
	`CFT_ASSERT_IMP(a_fill_bound, 1'b1, int'(fill_q) <= MAX_NEEDLE, "lookahead overfilled")
	`CFT_ASSERT_IMP(a_qemit_phase, st_q == ST_QEMIT, phase_q == PH_AFTER,
		"doubled quote replay outside the after-quote phase")
	`CFT_ASSERT_NXT(a_flush_last, flush && !stall, out_v_q && out_q.last && !hold_v_q,
		"closing word not marked last")

endmodule

// ===== hdl/csv_field_tokenizer.sv =====
// An input word passes the front end's pending register and the queue before the back end
// takes it; each result word then waits in the hold register before the output register.
// The back end takes a plain text byte into its lookahead and then emits it; each further
// result of the same input (field end with record check, doubled quote bytes) adds a step.
// Reset clears all parse state, the error flag and the queues, and loads the register defaults.
module csv_field_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  byte_out,
	output logic [1:0]  term_kind,
	output logic [15:0] field_index,
	output logic        is_header,
	output logic [31:0] line_no,
	output logic [2:0]  error_code,
	output logic        last
);
	import cft_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sep_bytes <= 32'd44;
			cfg_q.sep_len <= 3'd1;
			cfg_q.quote_bytes <= 32'd34;
			cfg_q.quote_len <= 3'd1;
			cfg_q.strict_mode <= 1'b0;
			cfg_q.header_mode <= 2'd0;
			cfg_q.header_count <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEP_BYTES:    cfg_q.sep_bytes <= cfg_data;
				REG_SEP_LEN:      cfg_q.sep_len <= cfg_data[2:0];
				REG_QUOTE_BYTES:  cfg_q.quote_bytes <= cfg_data;
				REG_QUOTE_LEN:    cfg_q.quote_len <= cfg_data[2:0];
				REG_STRICT_MODE:  cfg_q.strict_mode <= cfg_data[0];
				REG_HEADER_MODE:  cfg_q.header_mode <= cfg_data[1:0];
				REG_HEADER_COUNT: cfg_q.header_count <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.data       (data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	cft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	cft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign kind        = res.kind;
	assign byte_out    = res.byte_val;
	assign term_kind   = res.term;
	assign field_index = res.idx;
	assign is_header   = res.hdr;
	assign line_no     = res.line;
	assign error_code  = res.err;
	assign last        = res.last;

endmodule

// ===== bench/csv_token_checker.sv =====
`timescale 1ns / 1ps

module csv_token_checker
	import cft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_out,
	input  logic [1:0]  term_kind,
	input  logic [15:0] field_index,
	input  logic        is_header,
	input  logic [31:0] line_no,
	input  logic [2:0]  error_code,
	input  logic        last,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  b;
		logic [1:0]  term;
		logic [15:0] idx;
		logic        hdr;
		logic [31:0] line;
		logic [2:0]  err;
		logic        last;
	} token_t;

	typedef enum logic [1:0] {M_NO, M_YES, M_WAIT} match_t;

	token_t tokens_due[$];
	token_t step_tokens[$];

	logic [31:0] r_sep, r_quote;
	logic [2:0]  r_sep_len, r_quote_len;
	logic        r_strict;
	logic [1:0]  r_hmode;
	logic [15:0] r_hcount;

	logic [2:0]  phase;
	logic [7:0]  la [MAX_NEEDLE];
	int          fill;
	bit          cr_held;
	logic [1:0]  bom;
	logic [31:0] lines, field_line, rec_line;
	logic [15:0] nfields, nexpected;
	bit          have_exp, hdr_seen, rec_open, dead;

	function automatic int eff_len(input logic [2:0] l);
		if (l == 0)
			return 1;
		if (l > MAX_NEEDLE)
			return MAX_NEEDLE;
		return l;
	endfunction

	function automatic void clear_parse();
		phase = PH_REC;
		for (int i = 0; i < MAX_NEEDLE; i++)
			la[i] = 8'd0;
		fill = 0;
		cr_held = 0;
		bom = BOM_START;
		lines = 1;
		field_line = 1;
		rec_line = 1;
		nfields = 0;
		nexpected = 0;
		have_exp = 0;
		hdr_seen = 0;
		rec_open = 0;
	endfunction

	function automatic void push_token(input logic [1:0] k, input logic [7:0] b,
			input logic [1:0] t, input logic [15:0] idx, input logic h,
			input logic [31:0] ln, input logic [2:0] e);
		token_t tk;
		if (step_tokens.size() >= 5)
			return;
		tk = '{k, b, t, idx, h, ln, e, 1'b0};
		step_tokens.push_back(tk);
	endfunction

	function automatic logic header_rec();
		return r_hmode == HM_FIRST && !hdr_seen;
	endfunction

	function automatic void put_content(input logic [7:0] b);
		push_token(KIND_CONTENT, b, TERM_SEP, nfields, header_rec(), field_line, ERR_NONE);
	endfunction

	function automatic void raise_error(input logic [2:0] code, input logic [31:0] ln);
		push_token(KIND_ERROR, 8'd0, TERM_SEP, 16'd0, 1'b0, ln, code);
		dead = 1;
	endfunction

	function automatic void end_field(input logic [1:0] t);
		push_token(KIND_FIELD_END, 8'd0, t, nfields, header_rec(), field_line, ERR_NONE);
		if (nfields != 16'hFFFF)
			nfields++;
	endfunction

	function automatic void end_record();
		logic [15:0] want;
		bit          known, named;
		want = nexpected;
		known = have_exp;
		phase = PH_REC;
		rec_open = 0;
		if (r_hmode == HM_FIRST && !hdr_seen) begin
			hdr_seen = 1;
			nexpected = nfields;
			have_exp = 1;
			return;
		end
		if (r_hmode == HM_SUPPLIED) begin
			want = r_hcount;
			known = 1;
		end
		if (r_strict) begin
			if (!known) begin
				nexpected = nfields;
				have_exp = 1;
			end else if (nfields != want) begin
				raise_error(ERR_COUNT, rec_line);
				return;
			end
		end
		named = r_hmode == HM_SUPPLIED || (r_hmode == HM_FIRST && hdr_seen);
		if (named && nfields > want)
			raise_error(ERR_OVER_HEADER, rec_line);
	endfunction

	function automatic match_t match_at_head(input logic [31:0] pat, input logic [2:0] len,
			input bit eot);
		for (int i = 0; i < eff_len(len); i++) begin
			if (i >= fill)
				return eot ? M_NO : M_WAIT;
			if (la[i] != pat[8*i +: 8])
				return M_NO;
		end
		return M_YES;
	endfunction

	function automatic void drop(input int k);
		if (k > fill)
			k = fill;
		for (int i = 0; i < MAX_NEEDLE; i++)
			la[i] = (i + k < fill) ? la[i + k] : la[i];
		fill -= k;
	endfunction

	function automatic bit is_eol(input logic [7:0] b);
		return b == CH_LF || b == CH_CR;
	endfunction

	function automatic void line_up();
		if (lines != 32'hFFFFFFFF)
			lines++;
	endfunction

	function automatic void end_line(input logic [7:0] b);
		drop(1);
		line_up();
		if (b == CH_CR)
			cr_held = 1;
		end_field(TERM_EOL);
		end_record();
	endfunction

	// One decision at the head of the lookahead; returns 0 when more bytes are needed.
	function automatic bit decide(input bit eot);
		logic [7:0] b;
		match_t     t;
		b = la[0];
		if (cr_held) begin
			cr_held = 0;
			if (b == CH_LF) begin
				if (phase == PH_QUO)
					put_content(b);
				drop(1);
				return 1;
			end
		end
		case (phase)
			PH_REC: begin
				rec_line = lines;
				nfields = 0;
				rec_open = 1;
				phase = PH_FIELD;
			end
			PH_FIELD: begin
				field_line = lines;
				t = match_at_head(r_quote, r_quote_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					drop(eff_len(r_quote_len));
					phase = PH_QUO;
				end else begin
					phase = PH_UNQ;
				end
			end
			PH_UNQ: begin
				t = match_at_head(r_sep, r_sep_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					drop(eff_len(r_sep_len));
					end_field(TERM_SEP);
					phase = PH_FIELD;
					return 1;
				end
				if (is_eol(b)) begin
					end_line(b);
					return 1;
				end
				t = match_at_head(r_quote, r_quote_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					raise_error(ERR_STRAY_QUOTE, field_line);
					return 1;
				end
				put_content(b);
				drop(1);
			end
			PH_QUO: begin
				t = match_at_head(r_quote, r_quote_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					drop(eff_len(r_quote_len));
					phase = PH_AFTER;
					return 1;
				end
				put_content(b);
				if (is_eol(b)) begin
					line_up();
					if (b == CH_CR)
						cr_held = 1;
				end
				drop(1);
			end
			default: begin
				t = match_at_head(r_quote, r_quote_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					// A doubled quote gives the quote bytes once.
					for (int i = 0; i < eff_len(r_quote_len); i++)
						put_content(r_quote[8*i +: 8]);
					drop(eff_len(r_quote_len));
					phase = PH_QUO;
					return 1;
				end
				t = match_at_head(r_sep, r_sep_len, eot);
				if (t == M_WAIT)
					return 0;
				if (t == M_YES) begin
					drop(eff_len(r_sep_len));
					end_field(TERM_SEP);
					phase = PH_FIELD;
					return 1;
				end
				if (is_eol(b)) begin
					end_line(b);
					return 1;
				end
				raise_error(ERR_AFTER_QUOTE, field_line);
			end
		endcase
		return 1;
	endfunction

	function automatic void run_lookahead(input bit eot);
		while (!dead && fill > 0)
			if (!decide(eot))
				break;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		if (dead)
			return;
		if (fill < MAX_NEEDLE) begin
			la[fill] = b;
			fill++;
		end
		run_lookahead(0);
	endfunction

	function automatic void end_text();
		run_lookahead(1);
		if (!dead) begin
			case (phase)
				PH_FIELD: begin
					field_line = lines;
					end_field(TERM_EOT);
					end_record();
				end
				PH_UNQ, PH_AFTER: begin
					end_field(TERM_EOT);
					end_record();
				end
				PH_QUO: raise_error(ERR_UNTERMINATED, field_line);
				default: ;
			endcase
		end
		clear_parse();
	endfunction

	function automatic void predict_word(input logic o, input logic [7:0] b);
		token_t tk;
		step_tokens.delete();
		if (dead)
			return;
		if (o == 1'b0) begin
			case (bom)
				BOM_START: begin
					if (b == BOM_B0) begin
						bom = BOM_ONE;
					end else begin
						bom = BOM_DONE;
						take_byte(b);
					end
				end
				BOM_ONE: begin
					if (b == BOM_B1) begin
						bom = BOM_TWO;
					end else begin
						bom = BOM_DONE;
						take_byte(BOM_B0);
						take_byte(b);
					end
				end
				BOM_TWO: begin
					bom = BOM_DONE;
					if (b != BOM_B2) begin
						take_byte(BOM_B0);
						take_byte(BOM_B1);
						take_byte(b);
					end
				end
				default: take_byte(b);
			endcase
		end else begin
			if (bom == BOM_ONE) begin
				take_byte(BOM_B0);
			end else if (bom == BOM_TWO) begin
				take_byte(BOM_B0);
				take_byte(BOM_B1);
			end
			end_text();
		end
		for (int i = 0; i < step_tokens.size(); i++) begin
			tk = step_tokens[i];
			tk.last = (i == step_tokens.size() - 1);
			tokens_due.push_back(tk);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t seen, want;
		if (!arst_n) begin
			tokens_due.delete();
			clear_parse();
			dead = 0;
			r_sep = 32'd44;
			r_sep_len = 3'd1;
			r_quote = 32'd34;
			r_quote_len = 3'd1;
			r_strict = 0;
			r_hmode = 2'd0;
			r_hcount = 16'd0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEP_BYTES:    r_sep = cfg_data;
					REG_SEP_LEN:      r_sep_len = cfg_data[2:0];
					REG_QUOTE_BYTES:  r_quote = cfg_data;
					REG_QUOTE_LEN:    r_quote_len = cfg_data[2:0];
					REG_STRICT_MODE:  r_strict = cfg_data[0];
					REG_HEADER_MODE:  r_hmode = cfg_data[1:0];
					REG_HEADER_COUNT: r_hcount = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen = '{kind, byte_out, term_kind, field_index, is_header, line_no,
					error_code, last};
				if (tokens_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected result word %h", $realtime, seen);
					fails <= fails + 1;
				end else begin
					want = tokens_due.pop_front();
					if (seen !== want) begin
						if (fails < 10)
							$display("%0t: mismatch: expected %h, got %h", $realtime, want, seen);
						fails <= fails + 1;
					end
				end
			end
			if (in_valid && in_ready)
				predict_word(op, data);
			pending <= tokens_due.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cft_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_ready, op;
	logic [7:0]  data;
	logic        out_valid, out_ready;
	logic [1:0]  kind, term_kind;
	logic [7:0]  byte_out;
	logic [15:0] field_index;
	logic        is_header, last;
	logic [31:0] line_no;
	logic [2:0]  error_code;
	int          fails, pending;

	int          idle_pct, stall_pct, quiet;
	logic        hold;
	logic [31:0] sep, quote;
	int          slen, qlen;

	csv_field_tokenizer dut (.*);
	csv_token_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 0;
		else
			out_ready <= !hold && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic int eff_len(input int l);
		return l == 0 ? 1 : (l > MAX_NEEDLE ? MAX_NEEDLE : l);
	endfunction

	function automatic bit reserved_byte(input logic [7:0] b);
		if (b == CH_CR || b == CH_LF)
			return 1;
		for (int i = 0; i < 4; i++)
			if (b == sep[8*i +: 8] || b == quote[8*i +: 8])
				return 1;
		return 0;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = $urandom_range(255);
		while (reserved_byte(b));
		return b;
	endfunction

	task automatic put(input logic o, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		data <= b;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic put_needle(input logic [31:0] pat, input int n);
		for (int i = 0; i < n; i++)
			put(0, pat[8*i +: 8]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// Lets every expected word drain, then waits on for bytes still in flight.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic load_config(input logic [31:0] s, input int sl, input logic [31:0] q,
			input int ql, input bit strict, input int hm, input int hc);
		sep = s;
		quote = q;
		slen = eff_len(sl);
		qlen = eff_len(ql);
		write_reg(REG_SEP_BYTES, s);
		write_reg(REG_SEP_LEN, sl);
		write_reg(REG_QUOTE_BYTES, q);
		write_reg(REG_QUOTE_LEN, ql);
		write_reg(REG_STRICT_MODE, strict);
		write_reg(REG_HEADER_MODE, hm);
		write_reg(REG_HEADER_COUNT, hc);
	endtask

	function automatic void pick_needles();
		logic [7:0] pool [8];
		logic [7:0] b;
		bit         clash;
		for (int i = 0; i < 8; i++) begin
			do begin
				b = $urandom_range(255);
				clash = b == CH_CR || b == CH_LF || b == BOM_B0 || b == BOM_B1 || b == BOM_B2;
				for (int j = 0; j < i; j++)
					if (pool[j] == b)
						clash = 1;
			end while (clash);
			pool[i] = b;
		end
		sep = {pool[3], pool[2], pool[1], pool[0]};
		quote = {pool[7], pool[6], pool[5], pool[4]};
	endfunction

	task automatic quoted_field();
		put_needle(quote, qlen);
		repeat ($urandom_range(3)) begin
			case ($urandom_range(5))
				0: put(0, plain_byte());
				1: put_needle(sep, slen);
				2: put(0, CH_CR);
				3: put(0, CH_LF);
				4: begin
					put_needle(quote, qlen);
					put_needle(quote, qlen);
				end
				default: begin
					// A quote prefix that turns out not to be a quote.
					if (qlen > 1)
						put(0, quote[7:0]);
					put(0, plain_byte());
				end
			endcase
		end
		put_needle(quote, qlen);
	endtask

	task automatic plain_field();
		repeat ($urandom_range(3)) begin
			if (slen > 1 && $urandom_range(4) == 0)
				put(0, sep[7:0]);
			put(0, plain_byte());
		end
	endtask

	task automatic put_line_end();
		case ($urandom_range(2))
			0: put(0, CH_LF);
			1: put(0, CH_CR);
			default: begin
				put(0, CH_CR);
				put(0, CH_LF);
			end
		endcase
	endtask

	task automatic put_text(input int fixed);
		int nrec, nf;
		nrec = $urandom_range(1, 3);
		case ($urandom_range(5))
			0: begin
				put(0, BOM_B0);
				put(0, BOM_B1);
				put(0, BOM_B2);
			end
			1: put(0, BOM_B0);
			default: ;
		endcase
		for (int r = 0; r < nrec; r++) begin
			nf = fixed > 0 ? fixed : $urandom_range(1, 4);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					put_needle(sep, slen);
				if ($urandom_range(4) < 2)
					quoted_field();
				else
					plain_field();
			end
			if (r < nrec - 1 || $urandom_range(1))
				put_line_end();
		end
		put(1, $urandom_range(255));
	endtask

	task automatic directed();
		// Mark, doubled quote, CRLF inside quotes, and a last field at end of text.
		put(0, BOM_B0); put(0, BOM_B1); put(0, BOM_B2);
		put(0, 8'h22); put(0, 8'h78); put(0, 8'h22); put(0, 8'h22); put(0, 8'h0D);
		put(0, 8'h0A); put(0, 8'h22); put(0, 8'h2C); put(0, 8'hFF); put(0, 8'h0D);
		put(0, 8'h0A); put(0, 8'h00); put(0, 8'h2C); put(1, 8'h00);
		// Broken mark, then empty text, then a lone CR line end.
		put(0, BOM_B0); put(0, BOM_B1); put(1, 8'hFF);
		put(1, 8'h00);
		put(0, 8'h61); put(0, 8'h0D); put(1, 8'h00);
	endtask

	task automatic error_tail();
		int code;
		code = $urandom_range(1, 5);
		load_config(32'd44, 1, 32'd34, 1, code == 4, code == 5 ? HM_SUPPLIED : 0, 1);
		case (code)
			1: begin put(0, 8'h22); put(0, 8'h61); end
			2: begin put(0, 8'h22); put(0, 8'h61); put(0, 8'h22); put(0, 8'h62); end
			3: begin put(0, 8'h61); put(0, 8'h22); end
			4: begin
				put(0, 8'h61); put(0, 8'h2C); put(0, 8'h62); put(0, 8'h0A);
				put(0, 8'h61); put(0, 8'h0A);
			end
			default: begin put(0, 8'h61); put(0, 8'h2C); put(0, 8'h62); put(0, 8'h0A); end
		endcase
		put(1, 8'h00);
		// Once an error is out, the block stays silent.
		put(0, 8'h61); put(0, 8'h2C); put(1, 8'h00);
	endtask

	initial begin
		int sent_mark, fixed, hm, hc, sl, ql;
		bit strict;
		arst_n = 0;
		in_valid <= 0;
		op <= 0;
		data <= 0;
		cfg_valid <= 0;
		cfg_index <= 0;
		cfg_data <= 0;
		hold <= 0;
		idle_pct = 0;
		stall_pct = 0;
		sep = 32'd44;
		quote = 32'd34;
		slen = 1;
		qlen = 1;
		repeat (7) @(posedge clk);
		arst_n = 1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			pick_needles();
			strict = $urandom_range(1);
			hm = $urandom_range(3);
			hc = hm == HM_SUPPLIED ? $urandom_range(1, 4) : $urandom_range(16'hFFFF);
			sl = $urandom_range(7);
			ql = $urandom_range(7);
			if (ph == 0) begin
				sep = 32'd44;
				quote = 32'd34;
				sl = 0;
				ql = 7;
				hm = 0;
				hc = 16'hFFFF;
			end else if (ph == 1) begin
				sl = 4;
				ql = 4;
				hm = HM_FIRST;
				hc = 0;
			end
			load_config(sep, sl, quote, ql, strict, hm, hc);
			fixed = hm == HM_SUPPLIED ? hc : ((strict || hm != 0) ? $urandom_range(1, 4) : 0);
			idle_pct = (ph % 4 == 1) ? 63 : (ph % 4 == 3 ? 15 : 0);
			stall_pct = (ph % 4 == 2) ? 63 : (ph % 4 == 3 ? 15 : 0);
			if (ph == 4) begin
				fork
					begin
						hold <= 1;
						repeat (300) @(posedge clk);
						hold <= 0;
					end
				join_none
			end
			for (sent_mark = 0; sent_mark < 6; sent_mark++)
				put_text(fixed);
		end
		drain();
		idle_pct = 15;
		stall_pct = 15;
		error_tail();
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== csv_field_tokenizer.f =====
+incdir+hdl
hdl/cft_pkg.sv
hdl/cft_front.sv
hdl/cft_queue.sv
hdl/cft_back.sv
hdl/csv_field_tokenizer.sv
bench/csv_token_checker.sv
bench/testbench.sv
